### src/fsea_pkg.sv
// package for the four slot extent allocator
// holds widths, codes, fsm state type and the controller/datapath structs
// no dependencies
package fsea_pkg;

	localparam int NUM_SLOTS_DEF = 4;
	localparam int SW = 31;
	localparam int DW = 32;

	localparam logic [1:0] OP_ALLOC  = 2'd0;
	localparam logic [1:0] OP_FREE   = 2'd1;
	localparam logic [1:0] OP_RESIZE = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [1:0] FIT_FIRST = 2'd0;
	localparam logic [1:0] FIT_BEST  = 2'd1;
	localparam logic [1:0] FIT_WORST = 2'd2;
	localparam logic [1:0] FIT_NONE  = 2'd3;

	localparam logic [1:0] REG_DISK = 2'd0;
	localparam logic [1:0] REG_FIT  = 2'd1;
	localparam logic [1:0] REG_HDR  = 2'd2;
	localparam logic [1:0] REG_MINX = 2'd3;

	localparam logic [12:0] HDR_RESET  = 13'd128;
	localparam logic [12:0] MINX_RESET = 13'd32;

	localparam logic [3:0] STAT_OK         = 4'd0;
	localparam logic [3:0] STAT_NO_SLOT    = 4'd1;
	localparam logic [3:0] STAT_EXT_EXISTS = 4'd2;
	localparam logic [3:0] STAT_EXT_SMALL  = 4'd3;
	localparam logic [3:0] STAT_NO_GAP     = 4'd4;
	localparam logic [3:0] STAT_EMPTY      = 4'd5;
	localparam logic [3:0] STAT_NO_ROOM    = 4'd6;
	localparam logic [3:0] STAT_BAD_SIZE   = 4'd7;
	localparam logic [3:0] STAT_ZERO       = 4'd8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_STEP,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic scan;
		logic step;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic early;
		logic scan_last;
		logic best_found;
		logic is_alloc;
		logic out_free;
	} sts_t;

endpackage

### src/fsea_ifs.sv
// valid/ready channel interfaces: request, response and configuration
// depends on nothing
interface fsea_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [1:0]  slot;
	logic [30:0] req_size;
	logic        is_extended;
	logic signed [31:0] delta;
	modport source (output valid, opcode, slot, req_size, is_extended, delta, input ready);
	modport sink (input valid, opcode, slot, req_size, is_extended, delta, output ready);
endinterface

interface fsea_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [1:0]  out_slot;
	logic [30:0] out_start;
	logic [30:0] out_size;
	modport source (output valid, status, out_slot, out_start, out_size, input ready);
	modport sink (input valid, status, out_slot, out_start, out_size, output ready);
endinterface

interface fsea_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### src/fsea_ctrl.sv
// controller state machine of the extent allocator
// depends on fsea_pkg; drives datapath commands from its status
module fsea_ctrl import fsea_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = sts.early ? S_FINISH : S_SCAN;
			end
			S_SCAN: begin
				if (sts.scan_last) state_d = sts.is_alloc ? S_STEP : S_FINISH;
			end
			S_STEP: begin
				state_d = sts.best_found ? S_SCAN : S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_DECODE: cmd.decode = 1'b1;
			S_SCAN:   cmd.scan = 1'b1;
			S_STEP:   cmd.step = 1'b1;
			S_FINISH: cmd.commit = sts.out_free;
			default:  cmd = '0;
		endcase
	end
endmodule

### src/fsea_dp.sv
// datapath: extent table, config registers, gap scan and result register
// depends on fsea_pkg and the channel interfaces
module fsea_dp import fsea_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	fsea_in_if.sink      req,
	fsea_out_if.source   rsp,
	fsea_cfg_if.sink     cfg,
	input  cmd_t         cmd,
	output sts_t         sts
);
	localparam int IW = $clog2(NUM_SLOTS);
	localparam logic [IW-1:0] LAST = IW'(NUM_SLOTS - 1);

	logic [SW-1:0] ext_start_q [NUM_SLOTS];
	logic [SW-1:0] ext_size_q  [NUM_SLOTS];
	logic          ext_x_q     [NUM_SLOTS];

	logic [SW-1:0] disk_q;
	logic [1:0]    fit_q;
	logic [12:0]   hdr_q, minx_q;

	logic [1:0]    op_q, slot_q;
	logic [SW-1:0] reqsz_q;
	logic          isx_q;
	logic signed [DW-1:0] delta_q;

	logic [IW-1:0] free_slot_q, scan_q, best_idx_q;
	logic [NUM_SLOTS-1:0] cons_q;
	logic          best_found_q;
	logic [SW-1:0] best_start_q, next_q;
	logic [DW-1:0] cur_q, pick_start_q, pick_size_q;
	logic          pick_found_q;

	logic          early_q;
	logic [3:0]    est_q;
	logic [SW-1:0] estart_q, esize_q;

	logic          out_valid_q;
	logic [3:0]    out_status_q;
	logic [1:0]    out_slot_q;
	logic [SW-1:0] out_start_q, out_size_q;

	// slot decode
	logic [IW-1:0] sidx, fe;
	logic          in_range, any_empty, x_exists, sel_valid;
	logic [SW-1:0] cs, csz;

	always_comb begin
		sidx = IW'(slot_q);
		in_range = 32'(slot_q) < 32'(NUM_SLOTS);
		any_empty = 1'b0;
		x_exists = 1'b0;
		fe = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (ext_size_q[i] == '0) begin
				fe = IW'(i);
				any_empty = 1'b1;
			end
			if (ext_size_q[i] != '0 && ext_x_q[i]) x_exists = 1'b1;
		end
		cs  = in_range ? ext_start_q[sidx] : '0;
		csz = in_range ? ext_size_q[sidx] : '0;
		sel_valid = in_range && (csz != '0);
	end

	// early outcome
	logic          e_early;
	logic [3:0]    e_st;
	logic [SW-1:0] e_start, e_size;

	always_comb begin
		e_early = 1'b1;
		e_st = STAT_OK;
		e_start = '0;
		e_size = '0;
		case (op_q)
			OP_ALLOC: begin
				if (reqsz_q == '0) e_st = STAT_ZERO;
				else if (!any_empty) e_st = STAT_NO_SLOT;
				else if (isx_q && x_exists) e_st = STAT_EXT_EXISTS;
				else if (isx_q && reqsz_q <= SW'(minx_q)) e_st = STAT_EXT_SMALL;
				else e_early = 1'b0;
			end
			OP_FREE: begin
				if (!sel_valid) e_st = STAT_EMPTY;
				else e_start = cs;
			end
			OP_RESIZE: begin
				if (delta_q == '0) begin
					e_st = STAT_ZERO;
					e_start = cs;
					e_size = csz;
				end else if (!sel_valid) e_st = STAT_EMPTY;
				else e_early = 1'b0;
			end
			default: e_st = STAT_OK;
		endcase
	end

	// scan candidate
	logic          cand;
	logic [SW-1:0] sc_start;
	assign sc_start = ext_start_q[scan_q];

	always_comb begin
		if (op_q == OP_ALLOC)
			cand = ext_size_q[scan_q] != '0 && !cons_q[scan_q] &&
				(!best_found_q || sc_start < best_start_q);
		else
			cand = scan_q != sidx && ext_size_q[scan_q] != '0 &&
				sc_start > cs && sc_start < next_q;
	end

	// gap step
	logic [DW-1:0] s32, e32, g_start, g_size;
	logic          g_have, g_take;

	always_comb begin
		s32 = {1'b0, best_start_q};
		e32 = s32 + {1'b0, ext_size_q[best_idx_q]};
		g_have = 1'b0;
		g_start = cur_q;
		g_size = '0;
		if (best_found_q) begin
			if (s32 > cur_q) begin
				g_have = 1'b1;
				g_size = s32 - cur_q;
			end
		end else if (cur_q < {1'b0, disk_q}) begin
			g_have = 1'b1;
			g_size = {1'b0, disk_q} - cur_q;
		end
		g_take = 1'b0;
		if (g_have && g_size >= {1'b0, reqsz_q}) begin
			case (fit_q)
				FIT_FIRST: g_take = !pick_found_q;
				FIT_BEST:  g_take = !pick_found_q || g_size < pick_size_q;
				FIT_WORST: g_take = !pick_found_q || g_size > pick_size_q;
				default:   g_take = 1'b0;
			endcase
		end
	end

	// final outcome
	logic [3:0]    f_st;
	logic [1:0]    f_slot;
	logic [SW-1:0] f_start, f_size;
	logic signed [33:0] d34, room, ns;

	always_comb begin
		d34 = {{2{delta_q[DW-1]}}, delta_q};
		room = $signed({3'b0, next_q}) - $signed({3'b0, cs}) - $signed({3'b0, csz});
		ns = $signed({3'b0, csz}) + d34;
		f_slot = slot_q;
		f_st = est_q;
		f_start = estart_q;
		f_size = esize_q;
		if (!early_q) begin
			if (op_q == OP_ALLOC) begin
				if (pick_found_q) begin
					f_st = STAT_OK;
					f_slot = 2'(free_slot_q);
					f_start = pick_start_q[SW-1:0];
					f_size = reqsz_q;
				end else begin
					f_st = STAT_NO_GAP;
					f_slot = '0;
					f_start = '0;
					f_size = '0;
				end
			end else begin
				f_start = cs;
				f_size = csz;
				if (!delta_q[DW-1] && room < d34) f_st = STAT_NO_ROOM;
				else if (ns <= 34'sd0 || ns > 34'sd2147483647) f_st = STAT_BAD_SIZE;
				else begin
					f_st = STAT_OK;
					f_size = ns[SW-1:0];
				end
			end
		end else if (op_q == OP_ALLOC) begin
			f_slot = '0;
		end
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_q <= '0;
			fit_q <= FIT_FIRST;
			hdr_q <= HDR_RESET;
			minx_q <= MINX_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DISK: disk_q <= cfg.data[SW-1:0];
				REG_FIT:  fit_q <= cfg.data[1:0];
				REG_HDR:  hdr_q <= cfg.data[12:0];
				REG_MINX: minx_q <= cfg.data[12:0];
				default:  fit_q <= fit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SLOTS; i++) begin
				ext_start_q[i] <= '0;
				ext_size_q[i] <= '0;
				ext_x_q[i] <= 1'b0;
			end
		end else if (cmd.commit && f_st == STAT_OK) begin
			if (!early_q && op_q == OP_ALLOC) begin
				ext_start_q[free_slot_q] <= pick_start_q[SW-1:0];
				ext_size_q[free_slot_q] <= reqsz_q;
				ext_x_q[free_slot_q] <= isx_q;
			end else if (early_q && op_q == OP_FREE) begin
				ext_start_q[sidx] <= '0;
				ext_size_q[sidx] <= '0;
				ext_x_q[sidx] <= 1'b0;
			end else if (!early_q && op_q == OP_RESIZE) begin
				ext_size_q[sidx] <= f_size;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= req.opcode;
			slot_q <= req.slot;
			reqsz_q <= req.req_size;
			isx_q <= req.is_extended;
			delta_q <= req.delta;
		end
		if (cmd.decode) begin
			early_q <= e_early;
			est_q <= e_st;
			estart_q <= e_start;
			esize_q <= e_size;
			free_slot_q <= fe;
			cur_q <= {19'b0, hdr_q};
			next_q <= disk_q;
			cons_q <= '0;
			pick_found_q <= 1'b0;
			pick_start_q <= '0;
			pick_size_q <= '0;
		end
		if (cmd.decode || cmd.step) begin
			scan_q <= '0;
			best_found_q <= 1'b0;
		end
		if (cmd.scan) begin
			scan_q <= (scan_q == LAST) ? '0 : scan_q + 1'b1;
			if (cand) begin
				if (op_q == OP_ALLOC) begin
					best_found_q <= 1'b1;
					best_idx_q <= scan_q;
					best_start_q <= sc_start;
				end else begin
					next_q <= sc_start;
				end
			end
		end
		if (cmd.step) begin
			if (g_take) begin
				pick_found_q <= 1'b1;
				pick_start_q <= g_start;
				pick_size_q <= g_size;
			end
			if (best_found_q) begin
				cons_q[best_idx_q] <= 1'b1;
				if (e32 > cur_q) cur_q <= e32;
			end
		end
		if (cmd.commit) begin
			out_status_q <= f_st;
			out_slot_q <= f_slot;
			out_start_q <= f_start;
			out_size_q <= f_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.commit) out_valid_q <= 1'b1;
		else if (rsp.ready) out_valid_q <= 1'b0;
	end

	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.out_slot = out_slot_q;
	assign rsp.out_start = out_start_q;
	assign rsp.out_size = out_size_q;

	assign sts.early = e_early;
	assign sts.scan_last = scan_q == LAST;
	assign sts.best_found = best_found_q;
	assign sts.is_alloc = op_q == OP_ALLOC;
	assign sts.out_free = !out_valid_q || rsp.ready;
endmodule

### src/four_slot_extent_allocator_top.sv
// top level of the four slot extent allocator: controller plus datapath
// depends on fsea_pkg, fsea_ifs, fsea_ctrl and fsea_dp
// free, zero resize and allocate rejected at decode skip the scan and go straight to the word
// resize with a live slot: one slot a cycle next-start scan; allocate: an ordering scan and
// gap step per live extent plus a final one; arst_n clears control, config, table, out valid
// one word in flight, next taken the cycle after the response loads
module four_slot_extent_allocator_top import fsea_pkg::*; #(
	parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	fsea_cfg_if.sink   cfg,
	fsea_in_if.sink    req,
	fsea_out_if.source rsp
);
	cmd_t cmd;
	sts_t sts;

	fsea_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fsea_dp #(.NUM_SLOTS(NUM_SLOTS)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);
endmodule

### src/fsea_checker.sv
// port level checker for the extent allocator, bound to the top level
// depends on fsea_pkg for the status codes
module fsea_checker import fsea_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  status,
	input logic [30:0] out_size
);
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready after accept");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_size))
		else $error("stalled word changed");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STAT_ZERO)
		else $error("status out of range");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid in reset");
endmodule

bind four_slot_extent_allocator_top fsea_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.status    (rsp.status),
	.out_size  (rsp.out_size)
);
